[hdl/reversible_deque_assert.svh]
// Assertion macros for the reversible deque
`ifndef REVERSIBLE_DEQUE_ASSERT_SVH
`define REVERSIBLE_DEQUE_ASSERT_SVH

// same-cycle implication
`define RDQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/rdq_pkg.sv]
`default_nettype none

package rdq_pkg;

	localparam int DEPTH  = 1024;
	localparam int DATA_W = 32;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int SUM_W  = CNT_W + 1;

	typedef logic [2:0] mode_t;
	typedef logic [1:0] status_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [CNT_W-1:0] count_t;
	typedef logic [SUM_W-1:0] sum_t;

	localparam mode_t MODE_PUSH_REAR  = 3'd0;
	localparam mode_t MODE_PUSH_FRONT = 3'd1;
	localparam mode_t MODE_POP_FRONT  = 3'd2;
	localparam mode_t MODE_POP_BACK   = 3'd3;
	localparam mode_t MODE_REVERSE    = 3'd4;

	localparam status_t ST_ACK    = 2'd0;
	localparam status_t ST_POPPED = 2'd1;
	localparam status_t ST_EMPTY  = 2'd2;
	localparam status_t ST_FULL   = 2'd3;

	typedef struct packed {
		logic latch;
		logic exec;
		logic load_out;
	} ctrl_cmd_t;

	// ring index reduction; input is below twice the depth
	function automatic addr_t wrap_idx(input sum_t s);
		sum_t r;
		r = (s >= sum_t'(DEPTH)) ? s - sum_t'(DEPTH) : s;
		return r[ADDR_W-1:0];
	endfunction

endpackage

`default_nettype wire

[hdl/rdq_if.sv]
`default_nettype none

interface rdq_req_if;
	logic                valid;
	logic                ready;
	rdq_pkg::mode_t      mode;
	logic signed [31:0]  value;

	modport source (output valid, output mode, output value, input ready);
	modport sink (input valid, input mode, input value, output ready);
endinterface

interface rdq_rsp_if;
	logic                valid;
	logic                ready;
	rdq_pkg::status_t    status;
	logic signed [31:0]  popped_value;

	modport source (output valid, output status, output popped_value, input ready);
	modport sink (input valid, input status, input popped_value, output ready);
endinterface

`default_nettype wire

[hdl/reversible_deque.sv]
// Channel  Dir  Fields                 Handshake
// req      in   mode, value            valid/ready
// rsp      out  status, popped_value   valid/ready
//
// Each item passes through three steps: accept, ring access, result load.
// A pop reads its entry through the registered read port of the ring store.
// The next item is taken while a result still waits in the output register.
// Reset leaves the deque empty and not reversed; the store itself is not cleared.
// A stalled rsp holds a finished item in the result state, and req ready stays low.

`default_nettype none

`include "reversible_deque_assert.svh"

module reversible_deque (
	input  wire logic  clk,
	input  wire logic  arst_n,
	rdq_req_if.sink    req,
	rdq_rsp_if.source  rsp
);

	rdq_pkg::ctrl_cmd_t cmd;

	rdq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd)
	);

	rdq_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.mode         (req.mode),
		.value        (req.value),
		.status       (rsp.status),
		.popped_value (rsp.popped_value)
	);

	`RDQ_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, req.valid && req.ready, !req.ready,
		"req ready while an item is in flight")
	`RDQ_ASSERT_NEXT(a_exec_follows_accept, clk, arst_n, req.valid && req.ready, cmd.exec,
		"ring access missing after accept")
	`RDQ_ASSERT_NEXT(a_load_sets_valid, clk, arst_n, cmd.load_out, rsp.valid,
		"result load without rsp valid")
	`RDQ_ASSERT_NOW(a_cmd_onehot, clk, arst_n, 1'b1, $onehot0({cmd.latch, cmd.exec, cmd.load_out}),
		"overlapping controller commands")

endmodule

`default_nettype wire

[hdl/rdq_ctrl.sv]
`default_nettype none

module rdq_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_ready,
	output logic                    rsp_valid,
	input  wire logic               rsp_ready,
	output rdq_pkg::ctrl_cmd_t      cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       rsp_valid_q;
	logic       out_free;

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		state_d      = state_q;
		cmd.latch    = 1'b0;
		cmd.exec     = 1'b0;
		cmd.load_out = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

[hdl/rdq_datapath.sv]
`default_nettype none

module rdq_datapath (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire rdq_pkg::ctrl_cmd_t  cmd,
	input  wire rdq_pkg::mode_t      mode,
	input  wire logic signed [31:0]  value,
	output rdq_pkg::status_t         status,
	output logic signed [31:0]       popped_value
);

	logic [rdq_pkg::DATA_W-1:0] mem [rdq_pkg::DEPTH];

	rdq_pkg::addr_t   head_q;
	rdq_pkg::count_t  count_q;
	logic             rev_q;
	rdq_pkg::mode_t   mode_q;
	logic [rdq_pkg::DATA_W-1:0] value_q;
	logic [rdq_pkg::DATA_W-1:0] rd_q;
	rdq_pkg::status_t res_q;
	rdq_pkg::status_t status_q;
	logic signed [31:0] popped_q;

	logic is_push;
	logic is_pop;
	logic is_rev;
	logic full;
	logic empty;
	logic to_top;
	logic from_top;
	logic do_wr;
	logic do_rd;
	rdq_pkg::addr_t head_dec;
	rdq_pkg::addr_t head_inc;
	rdq_pkg::addr_t tail_wr;
	rdq_pkg::addr_t tail_rd;
	rdq_pkg::addr_t wr_addr;
	rdq_pkg::addr_t rd_addr;
	rdq_pkg::status_t res_d;
	rdq_pkg::sum_t  head_ext;

	assign is_push = mode_q inside {rdq_pkg::MODE_PUSH_REAR, rdq_pkg::MODE_PUSH_FRONT};
	assign is_pop  = mode_q inside {rdq_pkg::MODE_POP_FRONT, rdq_pkg::MODE_POP_BACK};
	assign is_rev  = (mode_q == rdq_pkg::MODE_REVERSE);
	assign full    = (count_q == rdq_pkg::count_t'(rdq_pkg::DEPTH));
	assign empty   = (count_q == '0);
	assign to_top   = (mode_q == rdq_pkg::MODE_PUSH_FRONT) ^ rev_q;
	assign from_top = (mode_q == rdq_pkg::MODE_POP_FRONT) ^ rev_q;

	assign head_ext = rdq_pkg::sum_t'(head_q);
	assign head_dec = (head_q == '0) ? rdq_pkg::addr_t'(rdq_pkg::DEPTH - 1)
	                                 : head_q - rdq_pkg::addr_t'(1);
	assign head_inc = rdq_pkg::wrap_idx(head_ext + rdq_pkg::sum_t'(1));
	assign tail_wr  = rdq_pkg::wrap_idx(head_ext + rdq_pkg::sum_t'(count_q));
	assign tail_rd  = rdq_pkg::wrap_idx(head_ext + rdq_pkg::sum_t'(count_q)
	                                    - rdq_pkg::sum_t'(1));

	assign do_wr   = cmd.exec && is_push && !full;
	assign do_rd   = cmd.exec && is_pop && !empty;
	assign wr_addr = to_top ? head_dec : tail_wr;
	assign rd_addr = from_top ? head_q : tail_rd;

	always_comb begin
		res_d = rdq_pkg::ST_ACK;
		if (is_push && full) begin
			res_d = rdq_pkg::ST_FULL;
		end else if (is_pop) begin
			res_d = empty ? rdq_pkg::ST_EMPTY : rdq_pkg::ST_POPPED;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem[wr_addr] <= value_q;
		end
		if (do_rd) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			mode_q  <= mode;
			value_q <= value[rdq_pkg::DATA_W-1:0];
		end
		if (cmd.exec) begin
			res_q <= res_d;
		end
		if (cmd.load_out) begin
			status_q <= res_q;
			popped_q <= (res_q == rdq_pkg::ST_POPPED) ? 32'(signed'(rd_q)) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			rev_q   <= 1'b0;
		end else begin
			if (do_wr) begin
				count_q <= count_q + rdq_pkg::count_t'(1);
				if (to_top) begin
					head_q <= head_dec;
				end
			end
			if (do_rd) begin
				count_q <= count_q - rdq_pkg::count_t'(1);
				if (from_top) begin
					head_q <= head_inc;
				end
			end
			if (cmd.exec && is_rev) begin
				rev_q <= !rev_q;
			end
		end
	end

	assign status       = status_q;
	assign popped_value = popped_q;

endmodule

`default_nettype wire

[tb/testbench.sv]
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		rdq_pkg::status_t   status;
		logic signed [31:0] popped;
	} deque_result_t;

	class deque_mirror;
		logic [rdq_pkg::DATA_W-1:0] slots [rdq_pkg::DEPTH];
		int                head;
		int                count;
		bit                flipped;
		deque_result_t     awaited [$];
		int                errors;
		int                items;
		int                tally [4];

		function void note_request(rdq_pkg::mode_t m, logic signed [31:0] v);
			deque_result_t r;
			int slot;
			bit top;
			r.status = rdq_pkg::ST_ACK;
			r.popped = '0;
			items++;
			case (m)
				rdq_pkg::MODE_PUSH_REAR, rdq_pkg::MODE_PUSH_FRONT: begin
					if (count >= rdq_pkg::DEPTH) begin
						r.status = rdq_pkg::ST_FULL;
					end else begin
						top = (m == rdq_pkg::MODE_PUSH_FRONT) != flipped;
						if (top) begin
							head = (head + rdq_pkg::DEPTH - 1) % rdq_pkg::DEPTH;
							slot = head;
						end else begin
							slot = (head + count) % rdq_pkg::DEPTH;
						end
						slots[slot] = v[rdq_pkg::DATA_W-1:0];
						count++;
					end
				end
				rdq_pkg::MODE_POP_FRONT, rdq_pkg::MODE_POP_BACK: begin
					if (count == 0) begin
						r.status = rdq_pkg::ST_EMPTY;
					end else begin
						top = (m == rdq_pkg::MODE_POP_FRONT) != flipped;
						if (top) begin
							slot = head;
							head = (head + 1) % rdq_pkg::DEPTH;
						end else begin
							slot = (head + count - 1) % rdq_pkg::DEPTH;
						end
						count--;
						r.popped = 32'(signed'(slots[slot]));
						r.status = rdq_pkg::ST_POPPED;
					end
				end
				rdq_pkg::MODE_REVERSE: begin
					flipped = !flipped;
				end
				default: ;
			endcase
			tally[r.status]++;
			awaited.insert(awaited.size(), r);
		endfunction

		function void check_result(rdq_pkg::status_t s, logic signed [31:0] p);
			deque_result_t e;
			if (awaited.size() == 0) begin
				$error("result with no item outstanding: status %0d, popped_value %0d", s, p);
				errors++;
				return;
			end
			e = awaited.pop_front();
			if (s !== e.status) begin
				$error("status: expected %0d, actual %0d", e.status, s);
				errors++;
			end
			if (p !== e.popped) begin
				$error("popped_value: expected %0d, actual %0d", e.popped, p);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	bit   steady;

	deque_mirror mirror = new();

	rdq_req_if req_ch ();
	rdq_rsp_if rsp_ch ();

	reversible_deque i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #5 clk = ~clk;

	task automatic send_request(rdq_pkg::mode_t m, logic signed [31:0] v);
		while (!steady && $urandom_range(0, 99) < 33) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.mode  <= m;
		req_ch.value <= v;
		do @(posedge clk); while (!req_ch.ready);
		mirror.note_request(m, v);
	endtask

	task automatic wait_quiet();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (mirror.awaited.size() != 0);
	endtask

	function automatic rdq_pkg::mode_t pick_mode(int push_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r >= 97)
			return rdq_pkg::MODE_REVERSE + rdq_pkg::mode_t'($urandom_range(1, 3));
		if (r >= 94)
			return rdq_pkg::MODE_REVERSE;
		if (r < push_pct)
			return $urandom_range(0, 1) ? rdq_pkg::MODE_PUSH_FRONT : rdq_pkg::MODE_PUSH_REAR;
		return $urandom_range(0, 1) ? rdq_pkg::MODE_POP_FRONT : rdq_pkg::MODE_POP_BACK;
	endfunction

	task automatic run_mix(int n, int push_pct);
		repeat (n) send_request(pick_mode(push_pct), $urandom());
	endtask

	initial begin
		arst_n       <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.mode  <= rdq_pkg::MODE_PUSH_REAR;
		req_ch.value <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty pops, extremes, both ends, reverse, undefined modes
		send_request(rdq_pkg::MODE_POP_FRONT, 32'sd1);
		send_request(rdq_pkg::MODE_POP_BACK, -32'sd1);
		send_request(rdq_pkg::MODE_PUSH_REAR, 32'sh7fffffff);
		send_request(rdq_pkg::MODE_PUSH_FRONT, 32'sh80000000);
		send_request(rdq_pkg::MODE_PUSH_REAR, 32'sd0);
		send_request(rdq_pkg::MODE_PUSH_REAR, -32'sd1);
		send_request(rdq_pkg::MODE_POP_FRONT, 32'sd0);
		send_request(rdq_pkg::MODE_POP_BACK, 32'sd0);
		send_request(rdq_pkg::MODE_REVERSE, 32'sh5a5a5a5a);
		send_request(rdq_pkg::MODE_PUSH_FRONT, 32'sd5);
		send_request(rdq_pkg::MODE_PUSH_REAR, 32'sd6);
		send_request(rdq_pkg::MODE_POP_FRONT, 32'sd0);
		send_request(rdq_pkg::MODE_POP_BACK, 32'sd0);
		send_request(rdq_pkg::MODE_REVERSE + rdq_pkg::mode_t'(1), 32'sh12345678);
		send_request(rdq_pkg::MODE_REVERSE + rdq_pkg::mode_t'(2), -32'sd7);
		send_request(rdq_pkg::MODE_REVERSE + rdq_pkg::mode_t'(3), 32'sh7fffffff);
		send_request(rdq_pkg::MODE_POP_FRONT, 32'sd0);
		send_request(rdq_pkg::MODE_POP_BACK, 32'sd0);
		send_request(rdq_pkg::MODE_POP_BACK, 32'sd0);
		send_request(rdq_pkg::MODE_REVERSE, 32'sd0);
		send_request(rdq_pkg::MODE_POP_FRONT, 32'sd0);

		steady = 1'b1;
		run_mix(150, 50);
		steady = 1'b0;
		wait_quiet();

		// fill to the brim, then knock on the full queue
		while (mirror.count < rdq_pkg::DEPTH) send_request(pick_mode(92), $urandom());
		run_mix(40, 92);
		run_mix(150, 50);

		wait_quiet();
		repeat (10) @(posedge clk);
		$display("%0d items sent: %0d pops returned, %0d pops on empty, %0d pushes dropped full",
			mirror.items, mirror.tally[rdq_pkg::ST_POPPED], mirror.tally[rdq_pkg::ST_EMPTY],
			mirror.tally[rdq_pkg::ST_FULL]);
		$display("queue filled to %0d entries, ends swapped %0s", rdq_pkg::DEPTH,
			"at random throughout");
		if (mirror.errors == 0 && mirror.awaited.size() == 0) begin
			$display("reversible_deque regression: pass");
		end else begin
			$display("reversible_deque regression: fail");
		end
		$finish;
	end

	initial begin
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready)
				mirror.check_result(rsp_ch.status, rsp_ch.popped_value);
			rsp_ch.ready <= steady || ($urandom_range(0, 99) >= 33);
		end
	end

	initial begin
		#5_000_000;
		$display("reversible_deque regression: fail");
		$finish;
	end

endmodule

`default_nettype wire
